@@ rtl/sms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_pkg
// Shared constants, op codes and stream layout for the stepper microstep
// sequencer.
// ----------------------------------------------------------------------------
package sms_pkg;

  // Default microsteps per quadrant
  localparam int unsigned MICROSTEPS_DEF = 16;

  // Target values
  localparam logic [31:0] PARKED_TARGET = 32'hFFFF_EEEE;
  localparam logic [31:0] RESET_TARGET  = 32'h00FF_FFFF;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned LEVEL_W     = 10;

  // Request op codes
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SET_POS = 3'd1,
    OP_SET_TGT = 3'd2,
    OP_SET_DIR = 3'd3,
    OP_WAVE_WR = 3'd4
  } op_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKLASH  = 1'd1;

endpackage

@@ rtl/sms_wave_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_wave_mem
// Wave level table: one write port, two registered read ports, per-entry
// valid bits so unwritten entries read as zero, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module sms_wave_mem
  import sms_pkg::*;
#(
  parameter int unsigned DEPTH = MICROSTEPS_DEF + 1,
  parameter int unsigned IDX_W = $clog2(MICROSTEPS_DEF + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [IDX_W-1:0]   waddr_i,
  input  logic [LEVEL_W-1:0] wdata_i,
  input  logic               rd_en_i,
  input  logic [IDX_W-1:0]   raddr_a_i,
  input  logic [IDX_W-1:0]   raddr_b_i,
  output logic [LEVEL_W-1:0] rdata_a_o,
  output logic [LEVEL_W-1:0] rdata_b_o
);

  logic [LEVEL_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]   valid_q;
  logic [LEVEL_W-1:0] rd_a_q, rd_b_q, wdata_q;
  logic               fwd_a_q, fwd_b_q, hit_a_q, hit_b_q;
  logic               fwd_a, fwd_b;

  assign fwd_a = we_i && (waddr_i == raddr_a_i);
  assign fwd_b = we_i && (waddr_i == raddr_b_i);

  // Write the table and read both ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rd_a_q  <= mem_q[raddr_a_i];
      rd_b_q  <= mem_q[raddr_b_i];
      wdata_q <= wdata_i;
    end
  end

  // Track written entries and the source of each read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        fwd_a_q <= fwd_a;
        fwd_b_q <= fwd_b;
        hit_a_q <= valid_q[raddr_a_i];
        hit_b_q <= valid_q[raddr_b_i];
      end
    end
  end

  // Resolve forwarded, stored or never-written data
  assign rdata_a_o = fwd_a_q ? wdata_q : (hit_a_q ? rd_a_q : '0);
  assign rdata_b_o = fwd_b_q ? wdata_q : (hit_b_q ? rd_b_q : '0);

endmodule

@@ rtl/stepper_microstep_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_microstep_sequencer_top
// Two-phase stepper microstep sequencer: position, target, direction,
// backlash take-up and quadrant phase, with winding levels from a wave table.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     tuser op, tdata value/index/level
// m_axis    out  m_axis_tvalid/tready     tdata levels, polarity, pos, target
// cfg       in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request per cycle is accepted while s_axis_tready is high; its result
// passes the result stage (state and wave read registered), then the output
// register. The throughput is set by the single state update path and the
// two-port wave table read.
// Reset clears all state at once; no clearing pass is needed.
// A stalled output fills the result stage, after which s_axis_tready drops.
// cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module stepper_microstep_sequencer_top
  import sms_pkg::*;
#(
  parameter int unsigned MICROSTEPS = MICROSTEPS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] value, [36:32] wave_index, [46:37] wave_value, [47] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] op
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [9:0] winding_a_level, [19:10] winding_b_level, [20] winding_a_negative,
  // [21] winding_b_negative, [53:22] position_now, [85:54] target_now,
  // [86] moving, [87] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned P_W   = $clog2(MICROSTEPS);
  localparam int unsigned IDX_W = $clog2(MICROSTEPS + 1);
  localparam int unsigned DEPTH = MICROSTEPS + 1;
  localparam logic [8:0]  CYC   = 9'(4 * MICROSTEPS);
  localparam logic [8:0]  MS9   = 9'(MICROSTEPS);

  // Reduce a signed step to whole quadrants and a remainder in microsteps
  function automatic logic [P_W+1:0] phase_step(input logic [4:0] mag,
                                                input logic       neg);
    logic [8:0] x;
    logic [1:0] qs;
    x  = {4'd0, mag};
    qs = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (x >= CYC) begin
        x = x - CYC;
      end
    end
    if (neg && (x != 9'd0)) begin
      x = CYC - x;
    end
    for (int k = 0; k < 3; k++) begin
      if (x >= MS9) begin
        x  = x - MS9;
        qs = qs + 2'd1;
      end
    end
    return {qs, x[P_W-1:0]};
  endfunction

  // Configuration registers
  logic [4:0] step_size_q;
  logic [7:0] backlash_lim_q;

  // Motion state
  logic [31:0]       pos_q, pos_d, tgt_q, tgt_d;
  logic signed [5:0] dir_q, dir_d;
  logic [1:0]        qs_q, qs_d, quad_q, quad_d;
  logic [P_W-1:0]    rs_q, rs_d, sub_q, sub_d;
  logic [7:0]        bl_q, bl_d;

  // Result stage and output stage
  logic              r_valid_q, o_valid_q;
  logic [31:0]       r_pos_q, r_tgt_q;
  logic              r_moving_q, r_neg_a_q, r_neg_b_q;
  logic [OUT_TDATA_W-1:0] o_data_q;

  logic              accept, advance;
  op_e               op;
  logic [31:0]       value;
  logic [4:0]        widx;
  logic [LEVEL_W-1:0] wval;
  logic [7:0]        widx8;
  logic              wave_we;
  logic [5:0]        mag;
  logic [8:0]        bl_sum;
  logic [P_W:0]      sub_sum;
  logic              sub_carry;
  logic [P_W+1:0]    step_new;
  logic [IDX_W-1:0]  addr_p, addr_j, addr_a, addr_b;
  logic [LEVEL_W-1:0] lvl_a, lvl_b;

  assign op     = op_e'(s_axis_tuser);
  assign value  = s_axis_tdata[31:0];
  assign widx   = s_axis_tdata[36:32];
  assign wval   = s_axis_tdata[46:37];
  assign widx8  = {3'd0, widx};

  // Handshake: result stage drains into the output register
  assign advance       = r_valid_q && (!o_valid_q || m_axis_tready);
  assign s_axis_tready = !r_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q    <= 5'd1;
      backlash_lim_q <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STEP_SIZE: step_size_q    <= cfg_data_i[4:0];
        CFG_BACKLASH:  backlash_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next motion state for the request
  always_comb begin
    pos_d    = pos_q;
    tgt_d    = tgt_q;
    dir_d    = dir_q;
    qs_d     = qs_q;
    rs_d     = rs_q;
    quad_d   = quad_q;
    sub_d    = sub_q;
    bl_d     = bl_q;
    wave_we  = 1'b0;
    mag      = dir_q[5] ? 6'(-dir_q) : 6'(dir_q);
    bl_sum   = {1'b0, bl_q} + {3'd0, mag};
    sub_sum  = {1'b0, sub_q} + {1'b0, rs_q};
    sub_carry = (sub_sum >= (P_W+1)'(MICROSTEPS));
    step_new = phase_step(step_size_q, value[31]);
    case (op)
      OP_TICK: begin
        if (dir_q != 6'sd0) begin
          if (pos_q == tgt_q) begin
            // Target reached: stop and park the target
            dir_d = 6'sd0;
            tgt_d = PARKED_TARGET;
          end else begin
            // Take up backlash before moving the position
            if (dir_q[5]) begin
              if (bl_q == 8'd0) begin
                pos_d = pos_q + {{26{dir_q[5]}}, dir_q};
              end else begin
                bl_d = (bl_q > {2'd0, mag}) ? bl_q - {2'd0, mag} : 8'd0;
              end
            end else begin
              if (bl_q == backlash_lim_q) begin
                pos_d = pos_q + {26'd0, dir_q};
              end else begin
                bl_d = (bl_sum > {1'b0, backlash_lim_q}) ? backlash_lim_q
                                                          : bl_sum[7:0];
              end
            end
            // Wrap the phase over four quadrants
            sub_d  = sub_carry ? P_W'(sub_sum - (P_W+1)'(MICROSTEPS))
                               : sub_sum[P_W-1:0];
            quad_d = quad_q + qs_q + {1'b0, sub_carry};
          end
        end
      end
      OP_SET_POS: pos_d = value;
      OP_SET_TGT: tgt_d = value;
      OP_SET_DIR: begin
        if (value == 32'd0) begin
          dir_d = 6'sd0;
        end else if (value[31]) begin
          dir_d = -$signed({1'b0, step_size_q});
        end else begin
          dir_d = $signed({1'b0, step_size_q});
        end
        qs_d = step_new[P_W+1:P_W];
        rs_d = step_new[P_W-1:0];
      end
      OP_WAVE_WR: wave_we = (widx8 < 8'(DEPTH));
      default: ;
    endcase
  end

  // Hold motion state; advance on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      tgt_q  <= RESET_TARGET;
      dir_q  <= 6'sd1;
      qs_q   <= 2'd0;
      rs_q   <= P_W'(1);
      quad_q <= 2'd0;
      sub_q  <= '0;
      bl_q   <= 8'd0;
    end else if (accept) begin
      pos_q  <= pos_d;
      tgt_q  <= tgt_d;
      dir_q  <= dir_d;
      qs_q   <= qs_d;
      rs_q   <= rs_d;
      quad_q <= quad_d;
      sub_q  <= sub_d;
      bl_q   <= bl_d;
    end
  end

  // Table addresses from the new phase
  assign addr_p = IDX_W'(sub_d);
  assign addr_j = IDX_W'(MICROSTEPS) - IDX_W'(sub_d);
  assign addr_a = quad_d[0] ? addr_p : addr_j;
  assign addr_b = quad_d[0] ? addr_j : addr_p;

  sms_wave_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_wave_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (accept && wave_we),
    .waddr_i   (widx8[IDX_W-1:0]),
    .wdata_i   (wval),
    .rd_en_i   (accept),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (lvl_a),
    .rdata_b_o (lvl_b)
  );

  // Result stage and output stage: valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        r_valid_q <= 1'b1;
      end else if (advance) begin
        r_valid_q <= 1'b0;
      end
      if (advance) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Result stage payload and output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_pos_q    <= pos_d;
      r_tgt_q    <= tgt_d;
      r_moving_q <= (dir_d != 6'sd0);
      r_neg_a_q  <= quad_d[1];
      r_neg_b_q  <= quad_d[1] ^ quad_d[0];
    end
    if (advance) begin
      o_data_q <= {1'b0, r_moving_q, r_tgt_q, r_pos_q, r_neg_b_q, r_neg_a_q,
                   lvl_b, lvl_a};
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_data_q;

endmodule

@@ rtl/sms_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_checker
// Port-level checks for the stepper microstep sequencer, bound to the top.
// ----------------------------------------------------------------------------
module sms_checker
  import sms_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Input backpressure only with a pending result
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // Empty output never blocks input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

  // Request into an empty block yields a result through the result stage and the output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result missing after request");

endmodule

bind stepper_microstep_sequencer_top sms_checker u_sms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
